### src/asc_pkg.sv
// Shared widths, payload types and helpers for the box/sphere contact pipeline.
package asc_pkg;

  localparam int COORD_W    = 32;               // signed Q16.16 coordinates
  localparam int EXT_W      = 30;               // half extents and radius
  localparam int DIFF_W     = COORD_W + 2;      // exact bound and offset width
  localparam int SQ_W       = 2 * EXT_W;        // square of an in-range offset
  localparam int SUM_W      = SQ_W + 2;         // sum of three squares
  localparam int REM_W      = EXT_W + 3;        // root remainder plus two new bits
  localparam int SQRT_STEPS = SQ_W / 2;         // one root bit per stage
  localparam int NRM_W      = 2;

  localparam logic signed [NRM_W-1:0] NRM_POS  = 2'sb01;
  localparam logic signed [NRM_W-1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [NRM_W-1:0] NRM_ZERO = 2'sb00;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_center_x;
    logic signed [COORD_W-1:0] box_center_y;
    logic signed [COORD_W-1:0] box_center_z;
    logic        [EXT_W-1:0]   box_half_x;
    logic        [EXT_W-1:0]   box_half_y;
    logic        [EXT_W-1:0]   box_half_z;
    logic signed [COORD_W-1:0] sphere_center_x;
    logic signed [COORD_W-1:0] sphere_center_y;
    logic signed [COORD_W-1:0] sphere_center_z;
    logic        [EXT_W-1:0]   sphere_radius;
  } in_t;

  // Payload carried through the square-root stages.
  typedef struct packed {
    logic [SQ_W-1:0]               v;       // radicand, consumed two bits a stage
    logic [REM_W-1:0]              rem;
    logic [EXT_W-1:0]              q;       // partial root
    logic [EXT_W-1:0]              radius;
    logic                          hit;
    logic signed [NRM_W-1:0]       normal_x;
    logic signed [NRM_W-1:0]       normal_y;
    logic signed [NRM_W-1:0]       normal_z;
  } sq_t;

  function automatic logic signed [NRM_W-1:0] sign_code(input logic neg, input logic nz);
    logic signed [NRM_W-1:0] res;
    res = NRM_ZERO;
    if (nz) begin
      res = neg ? NRM_NEG : NRM_POS;
    end
    return res;
  endfunction

endpackage

### src/asc_if.sv
// Request channel interfaces: box/sphere test requests in, contact results out.
interface asc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [asc_pkg::COORD_W-1:0] box_center_x;
  logic signed [asc_pkg::COORD_W-1:0] box_center_y;
  logic signed [asc_pkg::COORD_W-1:0] box_center_z;
  logic        [asc_pkg::EXT_W-1:0]   box_half_x;
  logic        [asc_pkg::EXT_W-1:0]   box_half_y;
  logic        [asc_pkg::EXT_W-1:0]   box_half_z;
  logic signed [asc_pkg::COORD_W-1:0] sphere_center_x;
  logic signed [asc_pkg::COORD_W-1:0] sphere_center_y;
  logic signed [asc_pkg::COORD_W-1:0] sphere_center_z;
  logic        [asc_pkg::EXT_W-1:0]   sphere_radius;

  modport source (
    output valid, box_center_x, box_center_y, box_center_z,
           box_half_x, box_half_y, box_half_z,
           sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, box_center_x, box_center_y, box_center_z,
           box_half_x, box_half_y, box_half_z,
           sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
    output ready
  );
endinterface

interface asc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [asc_pkg::NRM_W-1:0] normal_x;
  logic signed [asc_pkg::NRM_W-1:0] normal_y;
  logic signed [asc_pkg::NRM_W-1:0] normal_z;
  logic        [asc_pkg::EXT_W-1:0] penetration;

  modport source (
    output valid, hit, normal_x, normal_y, normal_z, penetration,
    input  ready
  );
  modport sink (
    input  valid, hit, normal_x, normal_y, normal_z, penetration,
    output ready
  );
endinterface

### src/asc_front.sv
// Front pipeline: clamp and offset, squares, then sum, hit test and dominant axis.
module asc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  asc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output asc_pkg::sq_t  out_data
);
  import asc_pkg::*;

  // stage 1: offsets from the closest box point
  logic                     v1_r;
  logic signed [DIFF_W-1:0] d1_r   [3];
  logic        [EXT_W-1:0]  rad1_r;
  logic signed [DIFF_W-1:0] d1_nxt [3];

  // stage 2: magnitudes, squares, far flag
  logic                     v2_r;
  logic        [SQ_W-1:0]   sq2_r  [3];
  logic        [EXT_W-1:0]  a2_r   [3];
  logic                     neg2_r [3];
  logic                     nz2_r  [3];
  logic        [SQ_W-1:0]   rr2_r;
  logic                     far2_r;
  logic        [EXT_W-1:0]  rad2_r;
  logic        [SQ_W-1:0]   sq2_nxt [3];
  logic        [DIFF_W-1:0] mag2    [3];
  logic        [EXT_W-1:0]  alo2    [3];
  logic        [SQ_W-1:0]   rr2_nxt;
  logic                     far2_nxt;

  // stage 3: root-chain entry
  logic                     v3_r;
  sq_t                      s3_r;
  sq_t                      s3_nxt;
  logic        [SUM_W-1:0]  sum3;
  logic        [1:0]        dom3;

  logic rdy1, rdy2, rdy3;

  logic signed [COORD_W-1:0] ctr [3];
  logic        [EXT_W-1:0]   hlf [3];
  logic signed [COORD_W-1:0] sph [3];

  assign ctr[0] = in_data.box_center_x;
  assign ctr[1] = in_data.box_center_y;
  assign ctr[2] = in_data.box_center_z;
  assign hlf[0] = in_data.box_half_x;
  assign hlf[1] = in_data.box_half_y;
  assign hlf[2] = in_data.box_half_z;
  assign sph[0] = in_data.sphere_center_x;
  assign sph[1] = in_data.sphere_center_y;
  assign sph[2] = in_data.sphere_center_z;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // bounds at full width so boxes past the coordinate range do not wrap
  always_comb begin
    logic signed [DIFF_W-1:0] c, h, s, lo, hi, cl;
    for (int i = 0; i < 3; i++) begin
      c  = {{(DIFF_W-COORD_W){ctr[i][COORD_W-1]}}, ctr[i]};
      h  = {{(DIFF_W-EXT_W){1'b0}}, hlf[i]};
      s  = {{(DIFF_W-COORD_W){sph[i][COORD_W-1]}}, sph[i]};
      lo = c - h;
      hi = c + h;
      if (s < lo) begin
        cl = lo;
      end else if (s > hi) begin
        cl = hi;
      end else begin
        cl = s;
      end
      d1_nxt[i] = s - cl;
    end
  end

  always_comb begin
    far2_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag2[i]    = d1_r[i][DIFF_W-1] ? DIFF_W'(-d1_r[i]) : DIFF_W'(d1_r[i]);
      alo2[i]    = mag2[i][EXT_W-1:0];
      sq2_nxt[i] = alo2[i] * alo2[i];
      if (mag2[i][DIFF_W-1:EXT_W] != '0) begin
        far2_nxt = 1'b1;
      end
    end
    rr2_nxt = rad1_r * rad1_r;
  end

  always_comb begin
    sum3 = SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
    dom3 = (a2_r[0] > a2_r[1]) ? 2'd0 : 2'd1;
    if (a2_r[dom3] < a2_r[2]) begin
      dom3 = 2'd2;
    end
    s3_nxt          = '0;
    s3_nxt.v        = sum3[SQ_W-1:0];
    s3_nxt.radius   = rad2_r;
    s3_nxt.hit      = !far2_r && (sum3 <= SUM_W'(rr2_r));
    if (s3_nxt.hit) begin
      s3_nxt.normal_x = (dom3 == 2'd0) ? sign_code(neg2_r[0], nz2_r[0]) : NRM_ZERO;
      s3_nxt.normal_y = (dom3 == 2'd1) ? sign_code(neg2_r[1], nz2_r[1]) : NRM_ZERO;
      s3_nxt.normal_z = (dom3 == 2'd2) ? sign_code(neg2_r[2], nz2_r[2]) : NRM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      d1_r   <= d1_nxt;
      rad1_r <= in_data.sphere_radius;
    end
    if (rdy2 && v1_r) begin
      sq2_r  <= sq2_nxt;
      rr2_r  <= rr2_nxt;
      far2_r <= far2_nxt;
      rad2_r <= rad1_r;
      for (int i = 0; i < 3; i++) begin
        a2_r[i]   <= alo2[i];
        neg2_r[i] <= d1_r[i][DIFF_W-1];
        nz2_r[i]  <= (d1_r[i] != '0);
      end
    end
    if (rdy3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

### src/asc_sqrt_step.sv
// One digit-by-digit square root stage: resolves one root bit per request.
module asc_sqrt_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  asc_pkg::sq_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output asc_pkg::sq_t out_data
);
  import asc_pkg::*;

  logic             valid_r;
  sq_t              data_r;
  sq_t              data_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    rem_sh        = {in_data.rem[REM_W-3:0], in_data.v[SQ_W-1 -: 2]};
    trial         = {1'b0, in_data.q, 2'b01};
    take          = (rem_sh >= trial);
    data_nxt      = in_data;
    data_nxt.v    = {in_data.v[SQ_W-3:0], 2'b00};
    data_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    data_nxt.q    = {in_data.q[EXT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/aabb_sphere_collision.sv
// Top level: pipelined axis-aligned box versus sphere contact test.
//
// Usage: in_chan carries one test request per handshake (box center and half
// extents, sphere center and radius, signed/unsigned Q16.16). out_chan returns
// exactly one result per request, in order: hit, a unit normal along the
// dominant offset axis (-1/0/+1 per axis) and the penetration depth.
// Pipeline: 3 front stages, 30 square root stages that each resolve one
// root bit, 1 output register. Throughput: one request per cycle while
// out_chan.ready is high; every stage has its own valid bit and the ready
// chain lets a stage fill whenever it is empty or its successor moves.
// Stalls: when out_chan.ready is low, requests keep entering until the pipe
// is full; only then does in_chan.ready drop. Nothing is dropped or repeated.
// Reset: synchronous, active low; clears all valid bits, no stored state.
// A miss (including any offset of 2^30 or more) returns all-zero fields.
module aabb_sphere_collision (
  input logic      clk,
  input logic      rst_n,
  asc_in_if.sink   in_chan,
  asc_out_if.source out_chan
);
  import asc_pkg::*;

  in_t  req;
  logic front_valid, front_ready;
  sq_t  front_data;

  // square root chain, index 0 is the front output
  logic chain_valid [SQRT_STEPS+1];
  logic chain_ready [SQRT_STEPS+1];
  sq_t  chain_data  [SQRT_STEPS+1];

  // output register
  logic             out_valid_r;
  logic             out_hit_r;
  logic signed [NRM_W-1:0] out_nx_r, out_ny_r, out_nz_r;
  logic [EXT_W-1:0] out_pen_r;
  logic             out_stage_ready;
  sq_t              last;

  assign req.box_center_x    = in_chan.box_center_x;
  assign req.box_center_y    = in_chan.box_center_y;
  assign req.box_center_z    = in_chan.box_center_z;
  assign req.box_half_x      = in_chan.box_half_x;
  assign req.box_half_y      = in_chan.box_half_y;
  assign req.box_half_z      = in_chan.box_half_z;
  assign req.sphere_center_x = in_chan.sphere_center_x;
  assign req.sphere_center_y = in_chan.sphere_center_y;
  assign req.sphere_center_z = in_chan.sphere_center_z;
  assign req.sphere_radius   = in_chan.sphere_radius;

  // clamp/offset, squares, sum/hit/dominant axis
  asc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (req),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  assign chain_valid[0] = front_valid;
  assign chain_data[0]  = front_data;
  assign front_ready    = chain_ready[0];

  // floor(sqrt) of the squared distance; 2*16 fraction bits in, 16 out
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    asc_sqrt_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  assign last            = chain_data[SQRT_STEPS];
  assign out_stage_ready = !out_valid_r || out_chan.ready;
  assign chain_ready[SQRT_STEPS] = out_stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_stage_ready) begin
      out_valid_r <= chain_valid[SQRT_STEPS];
    end
  end

  // on a hit the root never exceeds the radius, so the difference stays >= 0
  always_ff @(posedge clk) begin
    if (out_stage_ready && chain_valid[SQRT_STEPS]) begin
      out_hit_r <= last.hit;
      out_nx_r  <= last.normal_x;
      out_ny_r  <= last.normal_y;
      out_nz_r  <= last.normal_z;
      out_pen_r <= last.hit ? (last.radius - last.q) : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.normal_x    = out_nx_r;
  assign out_chan.normal_y    = out_ny_r;
  assign out_chan.normal_z    = out_nz_r;
  assign out_chan.penetration = out_pen_r;

`ifndef ASSERT_OFF
  // a miss carries no normal and no penetration
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.hit) |->
      (out_chan.normal_x == NRM_ZERO && out_chan.normal_y == NRM_ZERO &&
       out_chan.normal_z == NRM_ZERO && out_chan.penetration == '0))
    else $error("miss result with nonzero normal or penetration");

  // at most one normal axis is set
  a_one_axis : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      ($countones({out_chan.normal_x != NRM_ZERO, out_chan.normal_y != NRM_ZERO,
                   out_chan.normal_z != NRM_ZERO}) <= 1))
    else $error("more than one normal axis set");

  // reset empties the pipe
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the box/sphere contact pipeline.
//
// Requests go in on in_chan and results come back on out_chan, one result per
// request and in order. Every accepted request gets its expected result pushed
// onto a queue. That result is either typed into the directed table or worked
// out by a predictor with 64-bit arithmetic. The checker pops the oldest entry
// for each accepted result and compares the fields one at a time.
//
// Order of the run:
//   - Directed table: zero sizes, sphere center inside the box, exact touch,
//     just missing, the far-offset limit, ties between axes, and boxes that
//     reach past the 32-bit coordinate range.
//   - Drain, then random requests with idling on both sides.
//   - A burst during which the receiver holds ready low long enough for the
//     pipe to fill and the input to stall. A long stretch with no idling
//     follows it.
//   - Another drain, then more random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import asc_pkg::*;

  // Expected contact result, laid out like the out_chan payload.
  typedef struct packed {
    logic                    hit;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [EXT_W-1:0]        penetration;
  } contact_t;

  // One row of the directed table.
  typedef struct {
    in_t      rq;
    bit       fixed;     // 1: want is typed in, 0: the predictor supplies it
    contact_t want;
  } probe_t;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  localparam bit FIXED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam logic signed [COORD_W-1:0] C1    = 32'sh0001_0000;   // 1.0 in Q16.16
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic [EXT_W-1:0]          R1    = 30'h0001_0000;
  localparam logic [EXT_W-1:0]          R_MAX = 30'h3FFF_FFFF;
  localparam contact_t                  NO_CONTACT = '0;

  localparam int N_RANDOM    = 600;
  localparam int BURST_START = 200;
  localparam int BURST_LEN   = 80;
  localparam int STEADY_END  = 400;
  localparam int HOLD_CYCLES = 150;    // well past the 34-deep pipe
  localparam int TAIL_CYCLES = 40;     // catches any extra result after the queue drains

  logic clk = 1'b0;
  logic rst_n;

  asc_in_if  in_chan();
  asc_out_if out_chan();

  aabb_sphere_collision DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  contact_t pending_results[$];   // expected results, oldest first
  probe_t   probe_tab[$];
  int       mismatch_count = 0;
  int       results_seen   = 0;
  bit       steady         = 1'b0;   // no idling on either side
  bit       hold_wanted    = 1'b0;   // ask the receiver for one long hold-off

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  function automatic contact_t touch(logic signed [NRM_W-1:0] nx, logic signed [NRM_W-1:0] ny,
                                     logic signed [NRM_W-1:0] nz, logic [EXT_W-1:0] pen);
    return '{hit: 1'b1, normal_x: nx, normal_y: ny, normal_z: nz, penetration: pen};
  endfunction

  function automatic void add_probe(
    logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
    logic signed [COORD_W-1:0] cz, logic [EXT_W-1:0] hx, logic [EXT_W-1:0] hy,
    logic [EXT_W-1:0] hz, logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
    logic signed [COORD_W-1:0] sz, logic [EXT_W-1:0] r, bit fixed, contact_t want);
    probe_t p;
    p.rq    = '{cx, cy, cz, hx, hy, hz, sx, sy, sz, r};
    p.fixed = fixed;
    p.want  = want;
    probe_tab.push_back(p);
  endfunction

  // Contact predictor. Coordinates are widened to 64 bits, so box bounds never wrap.
  function automatic contact_t predict_contact(in_t rq);
    longint                  ctr[3], hlf[3], sph[3], off[3], mg[3];
    longint                  lo, hi, pt;
    longint unsigned         sum, rad, rem, root, bitv;
    logic signed [NRM_W-1:0] nrm;
    int                      dom;
    bit                      far;
    contact_t                res;
    ctr[AXIS_X] = longint'(rq.box_center_x);
    ctr[AXIS_Y] = longint'(rq.box_center_y);
    ctr[AXIS_Z] = longint'(rq.box_center_z);
    hlf[AXIS_X] = longint'(rq.box_half_x);
    hlf[AXIS_Y] = longint'(rq.box_half_y);
    hlf[AXIS_Z] = longint'(rq.box_half_z);
    sph[AXIS_X] = longint'(rq.sphere_center_x);
    sph[AXIS_Y] = longint'(rq.sphere_center_y);
    sph[AXIS_Z] = longint'(rq.sphere_center_z);
    rad = longint'(rq.sphere_radius);
    res = NO_CONTACT;
    far = 1'b0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      lo = ctr[i] - hlf[i];
      hi = ctr[i] + hlf[i];
      pt = sph[i];
      if (pt < lo) begin
        pt = lo;
      end else if (pt > hi) begin
        pt = hi;
      end
      off[i] = sph[i] - pt;
      mg[i]  = (off[i] < 0) ? -off[i] : off[i];
      if (mg[i] >= (longint'(1) << 30)) begin
        far = 1'b1;
      end
    end
    // Any offset of 2^30 or more is out of reach of every radius.
    if (far) begin
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      sum += longint'(mg[i]) * longint'(mg[i]);
    end
    if (sum > rad * rad) begin
      return res;
    end
    // Dominant axis: x must beat y strictly, and z must beat that winner strictly.
    dom = (mg[AXIS_X] > mg[AXIS_Y]) ? AXIS_X : AXIS_Y;
    if (mg[dom] < mg[AXIS_Z]) begin
      dom = AXIS_Z;
    end
    nrm = (off[dom] > 0) ? NRM_POS : (off[dom] < 0) ? NRM_NEG : NRM_ZERO;
    case (dom)
      AXIS_X: res.normal_x = nrm;
      AXIS_Y: res.normal_y = nrm;
      default: res.normal_z = nrm;
    endcase
    // floor(sqrt(sum)): Q32.32 in, Q16.16 out.
    root = 0;
    rem  = sum;
    bitv = 64'd1 << 62;
    while (bitv > rem) begin
      bitv >>= 2;
    end
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    res.hit         = 1'b1;
    res.penetration = EXT_W'(rad - root);
    return res;
  endfunction

  // Random request. Most of them put the sphere near the box. The others use
  // raw bit patterns, put the sphere center inside, or sit on the far limit.
  function automatic in_t draw_request();
    longint          ctr[3], hlf[3], sph[3], ex[3];
    int              side[3];
    longint unsigned rad;
    int              shape, hbits, rbits, j;
    in_t             rq;
    shape = $urandom_range(0, 99);
    hbits = $urandom_range(0, 30);
    rbits = $urandom_range(0, 30);
    rad   = 64'($urandom_range(0, 32'((64'd1 << rbits) - 1)));
    for (int i = 0; i < 3; i++) begin
      ctr[i]  = longint'($signed($urandom)) >>> $urandom_range(0, 24);
      hlf[i]  = longint'($urandom_range(0, 32'((64'd1 << hbits) - 1)));
      side[i] = 0;
      ex[i]   = 0;
      if (shape >= 30 && shape < 85) begin
        side[i] = int'($urandom_range(0, 2)) - 1;
        ex[i]   = longint'($urandom_range(0, 32'(rad + rad / 4 + 2)));
      end
    end
    if (shape >= 30 && shape < 85 && $urandom_range(0, 4) == 0) begin
      // tie between axes: copy the x offset magnitude onto y or z
      j       = $urandom_range(1, 2);
      side[j] = $urandom_range(0, 1) ? 1 : -1;
      if (side[AXIS_X] == 0) begin
        side[AXIS_X] = -side[j];
      end
      ex[j] = ex[AXIS_X];
    end else if (shape >= 85) begin
      // one axis right at the edge of the far limit, radius near the top
      j       = $urandom_range(0, 2);
      side[j] = $urandom_range(0, 1) ? 1 : -1;
      ex[j]   = (longint'(1) << 30) - 3 + longint'($urandom_range(0, 6));
      rad     = 64'(R_MAX) - 64'($urandom_range(0, 3));
    end
    for (int i = 0; i < 3; i++) begin
      if (side[i] == 0) begin
        sph[i] = ctr[i] + longint'($urandom_range(0, 32'(2 * hlf[i]))) - hlf[i];
      end else begin
        sph[i] = ctr[i] + side[i] * (hlf[i] + ex[i]);
      end
      if (shape < 15) begin
        // raw patterns, so every bit of every field is driven both ways
        ctr[i] = longint'($urandom);
        hlf[i] = longint'($urandom_range(0, 32'(R_MAX)));
        sph[i] = longint'($urandom);
      end
    end
    if (shape < 15) begin
      rad = 64'($urandom_range(0, 32'(R_MAX)));
    end
    rq.box_center_x    = COORD_W'(ctr[AXIS_X]);
    rq.box_center_y    = COORD_W'(ctr[AXIS_Y]);
    rq.box_center_z    = COORD_W'(ctr[AXIS_Z]);
    rq.box_half_x      = EXT_W'(hlf[AXIS_X]);
    rq.box_half_y      = EXT_W'(hlf[AXIS_Y]);
    rq.box_half_z      = EXT_W'(hlf[AXIS_Z]);
    rq.sphere_center_x = COORD_W'(sph[AXIS_X]);
    rq.sphere_center_y = COORD_W'(sph[AXIS_Y]);
    rq.sphere_center_z = COORD_W'(sph[AXIS_Z]);
    rq.sphere_radius   = EXT_W'(rad);
    return rq;
  endfunction

  // Offer one request, maybe after a short gap, and record what it should produce
  // once it is accepted. Valid stays high from one request to the next, so the
  // signal gets only one nonblocking assignment per edge.
  task automatic offer_request(in_t rq, bit fixed, contact_t want);
    if (!steady && $urandom_range(0, 99) < 8) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.box_center_x    <= rq.box_center_x;
    in_chan.box_center_y    <= rq.box_center_y;
    in_chan.box_center_z    <= rq.box_center_z;
    in_chan.box_half_x      <= rq.box_half_x;
    in_chan.box_half_y      <= rq.box_half_y;
    in_chan.box_half_z      <= rq.box_half_z;
    in_chan.sphere_center_x <= rq.sphere_center_x;
    in_chan.sphere_center_y <= rq.sphere_center_y;
    in_chan.sphere_center_z <= rq.sphere_center_z;
    in_chan.sphere_radius   <= rq.sphere_radius;
    // At the edge, ready still shows its value from before the edge.
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(fixed ? want : predict_contact(rq));
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    {in_chan.box_center_x, in_chan.box_center_y, in_chan.box_center_z} = '0;
    {in_chan.box_half_x, in_chan.box_half_y, in_chan.box_half_z} = '0;
    {in_chan.sphere_center_x, in_chan.sphere_center_y, in_chan.sphere_center_z} = '0;
    in_chan.sphere_radius = '0;

    // Directed table. Columns: box center, box half extents, sphere center,
    // radius, then whether the expected result is typed in below.
    // all-zero request: touching at distance zero
    add_probe(0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, 0));
    // sphere center inside the box: zero normal, full radius
    add_probe(0, 0, 0, EXT_W'(10 * R1), EXT_W'(10 * R1), EXT_W'(10 * R1),
              C1, 2 * C1, -3 * C1, R1,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, R1));
    add_probe(0, 0, 0, R_MAX, R_MAX, R_MAX, 0, 0, 0, R_MAX,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, R_MAX));
    // offsets of 2^30 or more: always a miss
    add_probe(0, 0, 0, 0, 0, 0, 32'sh4000_0000, 0, 0, R_MAX, FIXED, NO_CONTACT);
    add_probe(C_MAX, 0, 0, 0, 0, 0, C_MIN, 0, 0, R_MAX, FIXED, NO_CONTACT);
    add_probe(0, 0, 0, 0, 0, 0, 0, 0, -32'sh4000_0000, R_MAX, FIXED, NO_CONTACT);
    // exact touch on +x, then one LSB further out
    add_probe(0, 0, 0, R1, R1, R1, 2 * C1, 0, 0, R1,
              FIXED, touch(NRM_POS, NRM_ZERO, NRM_ZERO, 0));
    add_probe(0, 0, 0, R1, R1, R1, 2 * C1 + 1, 0, 0, R1, FIXED, NO_CONTACT);
    // face contacts on -y and +z
    add_probe(0, 0, 0, R1, R1, R1, 0, -3 * C1, 0, EXT_W'(4 * R1),
              FIXED, touch(NRM_ZERO, NRM_NEG, NRM_ZERO, EXT_W'(2 * R1)));
    add_probe(0, 0, 0, R1, R1, R1, 0, 0, 5 * C1, EXT_W'(5 * R1),
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_POS, R1));
    // ties: x=y, x=y=z, y=z, x=z; then z strictly largest
    add_probe(0, 0, 0, R1, R1, R1, 2 * C1, 2 * C1, 0, EXT_W'(2 * R1), PREDICT, NO_CONTACT);
    add_probe(0, 0, 0, R1, R1, R1, -2 * C1, 2 * C1, 2 * C1, EXT_W'(2 * R1),
              PREDICT, NO_CONTACT);
    add_probe(0, 0, 0, R1, R1, R1, 0, -2 * C1, 2 * C1, EXT_W'(2 * R1), PREDICT, NO_CONTACT);
    add_probe(0, 0, 0, R1, R1, R1, 3 * C1, 2 * C1, -3 * C1, EXT_W'(4 * R1),
              PREDICT, NO_CONTACT);
    add_probe(0, 0, 0, R1, R1, R1, 2 * C1, -2 * C1, -3 * C1, EXT_W'(4 * R1),
              PREDICT, NO_CONTACT);
    // boxes that reach past the coordinate range must not wrap
    add_probe(32'sh7FFF_0000, 0, 0, R_MAX, 0, 0, C_MAX, 0, 0, R1,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, R1));
    add_probe(C_MIN, 0, 0, R_MAX, 0, 0, C_MIN, 0, 0, R1,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, R1));
    add_probe(C_MAX, 0, 0, R_MAX, 0, 0, C_MIN, 0, 0, R_MAX, FIXED, NO_CONTACT);
    // every field at its extreme
    add_probe(C_MAX, C_MAX, C_MAX, R_MAX, R_MAX, R_MAX, C_MAX, C_MAX, C_MAX, R_MAX,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, R_MAX));
    add_probe(C_MIN, C_MIN, C_MIN, 0, 0, 0, C_MIN, C_MIN, C_MIN, 0,
              FIXED, touch(NRM_ZERO, NRM_ZERO, NRM_ZERO, 0));
    // largest offset still in reach: touch at full radius, miss one below
    add_probe(0, 0, 0, 0, 0, 0, 32'sh3FFF_FFFF, 0, 0, R_MAX,
              FIXED, touch(NRM_POS, NRM_ZERO, NRM_ZERO, 0));
    add_probe(0, 0, 0, 0, 0, 0, 32'sh3FFF_FFFF, 0, 0, EXT_W'(R_MAX - 1),
              FIXED, NO_CONTACT);
    add_probe(0, 0, 0, 0, 0, 0, 0, -32'sh3FFF_FFFF, 0, R_MAX,
              FIXED, touch(NRM_ZERO, NRM_NEG, NRM_ZERO, 0));
    // small fractional offset, root not exact
    add_probe(0, 0, 0, R1, R1, R1, C1 + 3, C1 + 5, 0, 7, PREDICT, NO_CONTACT);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_tab[k]) begin
      offer_request(probe_tab[k].rq, probe_tab[k].fixed, probe_tab[k].want);
    end
    // sender pauses until every outstanding request has come back
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < BURST_START; n++) begin
      offer_request(draw_request(), PREDICT, NO_CONTACT);
    end
    // Back-pressure: the receiver holds off while the sender offers a request
    // every cycle. The pipe fills and in_chan.ready has to drop. The stretch
    // with no idling then continues until STEADY_END.
    steady      = 1'b1;
    hold_wanted = 1'b1;
    for (int n = BURST_START; n < STEADY_END; n++) begin
      offer_request(draw_request(), PREDICT, NO_CONTACT);
    end
    steady = 1'b0;
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int n = STEADY_END; n < N_RANDOM; n++) begin
      offer_request(draw_request(), PREDICT, NO_CONTACT);
    end
    in_chan.valid <= 1'b0;

    // Wait for every result, then a little longer to catch any extra result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: checks each accepted result and drives out_chan.ready, with
  // random stalls and the one long hold-off, which it counts here.
  initial begin : result_check
    contact_t got, want;
    int       hold_left;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got = '{out_chan.hit, out_chan.normal_x, out_chan.normal_y, out_chan.normal_z,
                out_chan.penetration};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) begin
            report_mismatch($sformatf("result %0d: hit %0d, want %0d",
                                      results_seen, got.hit, want.hit));
          end
          if (got.normal_x !== want.normal_x) begin
            report_mismatch($sformatf("result %0d: normal_x %0d, want %0d",
                                      results_seen, got.normal_x, want.normal_x));
          end
          if (got.normal_y !== want.normal_y) begin
            report_mismatch($sformatf("result %0d: normal_y %0d, want %0d",
                                      results_seen, got.normal_y, want.normal_y));
          end
          if (got.normal_z !== want.normal_z) begin
            report_mismatch($sformatf("result %0d: normal_z %0d, want %0d",
                                      results_seen, got.normal_z, want.normal_z));
          end
          if (got.penetration !== want.penetration) begin
            report_mismatch($sformatf("result %0d: penetration 0x%0h, want 0x%0h",
                                      results_seen, got.penetration, want.penetration));
          end
        end
        results_seen++;
      end
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Timeout: ends a run that hangs and reports it as failed.
  initial begin : watchdog
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### aabb_sphere_collision.f
src/asc_pkg.sv
src/asc_if.sv
src/asc_front.sv
src/asc_sqrt_step.sv
src/aabb_sphere_collision.sv
verif/testbench.sv
